[rtl/core/isotp_pkg.sv]
package isotp_pkg;

	localparam logic [7:0]  FF_PCI        = 8'h10;
	localparam logic [7:0]  CF_PCI        = 8'h20;
	localparam logic [3:0]  NIBBLE        = 4'hF;
	localparam logic [7:0]  BYTE_MASK     = 8'hFF;
	localparam logic [15:0] MULTI_MAX_LEN = 16'd4095;
	localparam logic [11:0] SF_MAX_LEN    = 12'd7;
	localparam logic [11:0] FF_DATA_BYTES = 12'd6;

	localparam logic [1:0] KIND_SINGLE      = 2'd0;
	localparam logic [1:0] KIND_FIRST       = 2'd1;
	localparam logic [1:0] KIND_CONSECUTIVE = 2'd2;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [15:0] message_length;
		logic [10:0] can_identifier;
		logic        start_of_message;
	} item_t;

	typedef struct packed {
		logic [63:0] data;
		logic [3:0]  byte_count;
		logic [10:0] identifier;
		logic [1:0]  kind;
		logic        last;
	} frame_t;

endpackage

[rtl/core/isotp_in_stage.sv]
module isotp_in_stage import isotp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  item_t item_in,
	input  logic  advance,
	output logic  valid_s1,
	output item_t item_s1
);

	assign in_stall = valid_s1 & ~advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= item_in;
		end
	end

endmodule

[rtl/core/isotp_frame_builder.sv]
module isotp_frame_builder import isotp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   valid_s1,
	input  item_t  item_s1,
	input  logic   advance,
	output logic   emit,
	output frame_t frame
);

	logic [63:0] fb_q, fb_d;
	logic [3:0]  bif_q, bif_d;
	logic [11:0] br_q, br_d;
	logic [11:0] tl_q, tl_d;
	logic [3:0]  seq_q, seq_d;
	logic [10:0] id_q, id_d;
	logic        rej_q, rej_d;
	logic        full, last, single;
	logic [1:0]  kind;

	function automatic logic [63:0] put_byte(logic [63:0] fb, logic [2:0] pos, logic [7:0] b);
		return fb | ({b & BYTE_MASK, 56'h0} >> {pos, 3'b000});
	endfunction

	always_comb begin
		fb_d   = fb_q;
		bif_d  = bif_q;
		br_d   = br_q;
		tl_d   = tl_q;
		seq_d  = seq_q;
		id_d   = id_q;
		rej_d  = rej_q;
		emit   = 1'b0;
		full   = 1'b0;
		last   = 1'b0;
		single = 1'b0;
		kind   = KIND_SINGLE;
		if (item_s1.start_of_message) begin
			tl_d  = item_s1.message_length[11:0];
			id_d  = item_s1.can_identifier;
			br_d  = '0;
			bif_d = '0;
			seq_d = 4'd1;
			fb_d  = '0;
			rej_d = (item_s1.message_length == 16'd0) ||
				(item_s1.message_length > MULTI_MAX_LEN);
			if (!rej_d) begin
				if (item_s1.message_length[11:0] <= SF_MAX_LEN) begin
					fb_d  = put_byte(fb_d, 3'd0, item_s1.message_length[7:0]);
					bif_d = 4'd1;
				end else begin
					fb_d  = put_byte(fb_d, 3'd0,
						FF_PCI | {4'h0, item_s1.message_length[11:8]});
					fb_d  = put_byte(fb_d, 3'd1, item_s1.message_length[7:0]);
					bif_d = 4'd2;
				end
			end
		end
		if (!rej_d && (br_d < tl_d)) begin
			if (bif_d == 4'd0) begin
				fb_d  = put_byte(fb_d, 3'd0, CF_PCI | {4'h0, seq_d & NIBBLE});
				bif_d = 4'd1;
			end
			fb_d   = put_byte(fb_d, bif_d[2:0], item_s1.data_byte);
			bif_d  = bif_d + 4'd1;
			br_d   = br_d + 12'd1;
			full   = bif_d[3];
			last   = (br_d == tl_d);
			single = (tl_d <= SF_MAX_LEN);
			if (single) begin
				emit = last;
				kind = KIND_SINGLE;
			end else begin
				emit = full | last;
				kind = (br_d == FF_DATA_BYTES) ? KIND_FIRST : KIND_CONSECUTIVE;
			end
		end
		frame.data       = fb_d;
		frame.byte_count = bif_d;
		frame.identifier = id_d;
		frame.kind       = kind;
		frame.last       = last;
		if (emit) begin
			if (kind == KIND_CONSECUTIVE) begin
				seq_d = (seq_d + 4'd1) & NIBBLE;
			end
			fb_d  = '0;
			bif_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_q  <= '0;
			bif_q <= '0;
			br_q  <= '0;
			tl_q  <= '0;
			seq_q <= 4'd1;
			id_q  <= '0;
			rej_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			fb_q  <= fb_d;
			bif_q <= bif_d;
			br_q  <= br_d;
			tl_q  <= tl_d;
			seq_q <= seq_d;
			id_q  <= id_d;
			rej_q <= rej_d;
		end
	end

endmodule

[rtl/core/isotp_out_stage.sv]
module isotp_out_stage import isotp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   valid_s1,
	input  logic   emit,
	input  frame_t frame,
	output logic   advance,
	output logic   out_valid,
	input  logic   out_stall,
	output frame_t frame_q
);

	logic out_valid_q;

	assign advance   = ~out_valid_q | ~out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 & emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			frame_q <= frame;
		end
	end

endmodule

[rtl/core/isotp_tx_segmenter_unit.sv]
// ISO-TP transmit segmenter.
// Input channel (in_valid / in_stall): one payload byte per word, in order.
// The word with start_of_message set also carries message_length and
// can_identifier. Lengths 1..7 give one single frame, 8..4095 a first frame
// followed by consecutive frames; zero or above 4095 is swallowed whole.
// Output channel (out_valid / out_stall): one CAN frame per word, left
// aligned in frame_data, unpadded, with byte count, identifier, kind and
// a last-frame flag.
// Throughput: one byte per cycle while no stalled output frame is held;
// the frame builder logic is combinational between the input register
// and the output register, where a frame is registered after the byte
// that completes it has passed the input register.
// Reset: no frame pending, no message open, sequence number back to one.
// A stalled output frame is held; the input register then fills and
// in_stall rises until the frame is taken.
module isotp_tx_segmenter_unit import isotp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic [15:0] message_length,
	input  logic [10:0] can_identifier,
	input  logic        start_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] frame_data,
	output logic [3:0]  frame_byte_count,
	output logic [10:0] frame_identifier,
	output logic [1:0]  frame_kind,
	output logic        last_frame
);

	item_t  item_in, item_s1;
	frame_t frame, frame_q;
	logic   valid_s1, advance, emit;

	assign item_in.data_byte        = data_byte;
	assign item_in.message_length   = message_length;
	assign item_in.can_identifier   = can_identifier;
	assign item_in.start_of_message = start_of_message;

	isotp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item_in  (item_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	isotp_frame_builder u_build (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.advance  (advance),
		.emit     (emit),
		.frame    (frame)
	);

	isotp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.emit      (emit),
		.frame     (frame),
		.advance   (advance),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.frame_q   (frame_q)
	);

	assign frame_data       = frame_q.data;
	assign frame_byte_count = frame_q.byte_count;
	assign frame_identifier = frame_q.identifier;
	assign frame_kind       = frame_q.kind;
	assign last_frame       = frame_q.last;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while output free");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_byte_count != 4'd0 && frame_byte_count <= 4'd8))
		else $error("frame byte count out of range");

	a_first_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_kind == KIND_FIRST) |-> (frame_byte_count == 4'd8 && !last_frame))
		else $error("malformed first frame");

	a_single_pci: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_kind == KIND_SINGLE) |->
		(last_frame && frame_data[63:56] == {4'h0, frame_byte_count - 4'd1}))
		else $error("single frame PCI mismatch");

endmodule

[verif/tb.sv]
module tb;
	import isotp_pkg::*;

	class isotp_frame_predictor;
		logic [63:0] build_buf;
		int unsigned fill;
		int unsigned taken;
		int unsigned length;
		logic [3:0]  seq_num;
		logic [10:0] ident;
		bit          rejected;
		frame_t      frames_due[$];
		int          errors;

		function new();
			build_buf = '0;
			fill      = 0;
			taken     = 0;
			length    = 0;
			seq_num   = 4'd1;
			ident     = '0;
			rejected  = 1'b0;
			errors    = 0;
		endfunction

		function void place(int unsigned pos, logic [7:0] b);
			build_buf[63 - 8 * pos -: 8] = b;
		endfunction

		// returns 1 when the word goes into a frame
		function bit note_word(item_t w);
			frame_t     f;
			bit         full;
			bit         last;
			bit         emit;
			logic [1:0] kind;
			if (w.start_of_message) begin
				length    = 32'(w.message_length);
				ident     = w.can_identifier;
				taken     = 0;
				fill      = 0;
				seq_num   = 4'd1;
				build_buf = '0;
				rejected  = (w.message_length == 16'd0) || (w.message_length > MULTI_MAX_LEN);
				if (!rejected) begin
					if (length <= SF_MAX_LEN) begin
						place(0, w.message_length[7:0]);
						fill = 1;
					end else begin
						place(0, FF_PCI | {4'h0, w.message_length[11:8]});
						place(1, w.message_length[7:0]);
						fill = 2;
					end
				end
			end
			if (rejected || taken >= length)
				return 1'b0;
			if (fill == 0) begin
				place(0, CF_PCI | {4'h0, seq_num});
				fill = 1;
			end
			place(fill, w.data_byte);
			fill++;
			taken++;
			full = fill >= 8;
			last = taken == length;
			if (length <= SF_MAX_LEN) begin
				emit = last;
				kind = KIND_SINGLE;
			end else begin
				emit = full || last;
				kind = (taken == FF_DATA_BYTES) ? KIND_FIRST : KIND_CONSECUTIVE;
			end
			if (emit) begin
				f.data       = build_buf;
				f.byte_count = fill[3:0];
				f.identifier = ident;
				f.kind       = kind;
				f.last       = last;
				frames_due.insert(frames_due.size(), f);
				if (kind == KIND_CONSECUTIVE)
					seq_num = seq_num + 4'd1;
				build_buf = '0;
				fill      = 0;
			end
			return 1'b1;
		endfunction

		function void check_frame(frame_t got);
			frame_t want;
			if (frames_due.size() == 0) begin
				$error("frame with none due: data %h count %0d", got.data, got.byte_count);
				errors++;
				return;
			end
			want = frames_due.pop_front();
			if (got.data !== want.data) begin
				$error("frame_data: expected %h, got %h", want.data, got.data);
				errors++;
			end
			if (got.byte_count !== want.byte_count) begin
				$error("frame_byte_count: expected %0d, got %0d", want.byte_count, got.byte_count);
				errors++;
			end
			if (got.identifier !== want.identifier) begin
				$error("frame_identifier: expected %h, got %h", want.identifier, got.identifier);
				errors++;
			end
			if (got.kind !== want.kind) begin
				$error("frame_kind: expected %0d, got %0d", want.kind, got.kind);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last_frame: expected %0d, got %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_e;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic [15:0] message_length;
	logic [10:0] can_identifier;
	logic        start_of_message;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] frame_data;
	logic [3:0]  frame_byte_count;
	logic [10:0] frame_identifier;
	logic [1:0]  frame_kind;
	logic        last_frame;

	isotp_frame_predictor sb = new();

	int          burst_left = 0;
	int          bytes_used = 0;
	stall_mode_e stall_mode = STALL_NONE;
	int          mode_left  = 0;
	int          phase      = 0;

	isotp_tx_segmenter_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.data_byte        (data_byte),
		.message_length   (message_length),
		.can_identifier   (can_identifier),
		.start_of_message (start_of_message),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.frame_data       (frame_data),
		.frame_byte_count (frame_byte_count),
		.frame_identifier (frame_identifier),
		.frame_kind       (frame_kind),
		.last_frame       (last_frame)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		frame_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.data       = frame_data;
			got.byte_count = frame_byte_count;
			got.identifier = frame_identifier;
			got.kind       = frame_kind;
			got.last       = last_frame;
			sb.check_frame(got);
		end
		if (mode_left == 0) begin
			stall_mode = stall_mode_e'($urandom_range(0, 2));
			mode_left  = $urandom_range(16, 200);
		end else begin
			mode_left--;
		end
		phase++;
		case (stall_mode)
			STALL_NONE:     out_stall <= 1'b0;
			STALL_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
			STALL_PERIODIC: out_stall <= ((phase % 5) < 3);
			default:        out_stall <= 1'b0;
		endcase
	end

	task automatic send_word(input item_t w);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
			                                          : $urandom_range(1, 20);
		end
		in_valid         <= 1'b1;
		data_byte        <= w.data_byte;
		message_length   <= w.message_length;
		can_identifier   <= w.can_identifier;
		start_of_message <= w.start_of_message;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (sb.note_word(w))
			bytes_used++;
		burst_left--;
	endtask

	// first word opens the message, the rest carry junk in the header fields
	task automatic send_message(input logic [15:0] len, input logic [10:0] ident, input int nbytes);
		item_t w;
		for (int i = 0; i < nbytes; i++) begin
			w.data_byte        = 8'($urandom_range(0, 255));
			w.start_of_message = (i == 0);
			w.message_length   = (i == 0) ? len : 16'($urandom_range(0, 65535));
			w.can_identifier   = (i == 0) ? ident : 11'($urandom_range(0, 2047));
			send_word(w);
		end
	endtask

	task automatic send_stray(input int n);
		item_t w;
		for (int i = 0; i < n; i++) begin
			w.data_byte        = 8'($urandom_range(0, 255));
			w.start_of_message = 1'b0;
			w.message_length   = 16'($urandom_range(0, 65535));
			w.can_identifier   = 11'($urandom_range(0, 2047));
			send_word(w);
		end
	endtask

	task automatic send_fixed(input logic [7:0] b, input logic [15:0] len, input logic [10:0] ident);
		item_t w;
		w.data_byte        = b;
		w.message_length   = len;
		w.can_identifier   = ident;
		w.start_of_message = 1'b1;
		send_word(w);
	endtask

	initial begin
		int pick;
		int len;
		arst_n           <= 1'b0;
		in_valid         <= 1'b0;
		data_byte        <= '0;
		message_length   <= '0;
		can_identifier   <= '0;
		start_of_message <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		send_stray(1);
		send_fixed(8'hFF, 16'd1, 11'h7FF);
		send_fixed(8'h00, 16'd1, 11'h000);
		send_message(16'd0, 11'h123, 2);
		send_message(16'd4096, 11'h321, 2);
		send_message(16'hFFFF, 11'h456, 1);
		send_message(16'd8, 11'h555, 8);
		send_stray(1);
		send_message(16'd7, 11'h2AA, 2);
		send_message(16'd2, 11'h0F0, 2);

		// random
		while (bytes_used < 600) begin
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				len = $urandom_range(1, 7);
				send_message(16'(len), 11'($urandom_range(0, 2047)), len);
			end else if (pick < 55) begin
				len = $urandom_range(8, 48);
				send_message(16'(len), 11'($urandom_range(0, 2047)), len);
			end else if (pick < 62) begin
				len = $urandom_range(112, 140);
				send_message(16'(len), 11'($urandom_range(0, 2047)), len);
			end else if (pick < 72) begin
				// long header, usually cut short by the next start
				send_message(16'($urandom_range(8, 4095)), 11'($urandom_range(0, 2047)),
				             $urandom_range(1, 20));
			end else if (pick < 80) begin
				len = $urandom_range(2, 48);
				send_message(16'(len), 11'($urandom_range(0, 2047)),
				             $urandom_range(1, len - 1));
			end else if (pick < 86) begin
				if ($urandom_range(0, 3) == 0)
					len = 0;
				else
					len = int'({4'($urandom_range(1, 15)), 12'($urandom_range(0, 4095))});
				send_message(16'(len), 11'($urandom_range(0, 2047)), $urandom_range(1, 4));
			end else if (pick < 94) begin
				len = $urandom_range(1, 20);
				send_message(16'(len), 11'($urandom_range(0, 2047)),
				             len + $urandom_range(1, 3));
			end else begin
				send_stray($urandom_range(1, 3));
			end
		end
		in_valid <= 1'b0;

		while (sb.frames_due.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (sb.frames_due.size() != 0)
			$error("%0d frames never arrived", sb.frames_due.size());
		if (sb.errors == 0 && sb.frames_due.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#3000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
